/* rtl/slru_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slru_pkg
// Shared types and codes for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package slru_pkg;

    localparam int ACT_W      = 2;
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int CNT32_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // access actions
    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STORE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MODIFY = 2'd2;
    localparam logic [ACT_W-1:0] ACT_IFETCH = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

    // lookup outcome handed from the update logic to the top level
    typedef struct packed {
        logic hit;
        logic evict;
    } slru_status_t;

endpackage : slru_pkg
`default_nettype wire

/* rtl/slru_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slru_if
// Valid/ready channels: access requests in, per-access results out.
// ----------------------------------------------------------------------------
interface slru_req_if;
    import slru_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] access_address;

    modport source (output valid, output action, output access_address, input ready);
    modport sink   (input valid, input action, input access_address, output ready);
endinterface : slru_req_if

interface slru_rsp_if;
    import slru_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic               evicted;
    logic               last;
    logic [CNT32_W-1:0] hit_count;
    logic [CNT32_W-1:0] miss_count;
    logic [CNT32_W-1:0] eviction_count;

    modport source (output valid, output hit, output evicted, output last,
                    output hit_count, output miss_count, output eviction_count,
                    input ready);
    modport sink   (input valid, input hit, input evicted, input last,
                    input hit_count, input miss_count, input eviction_count,
                    output ready);
endinterface : slru_rsp_if
`default_nettype wire

/* rtl/slru_update.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slru_update
// Tag match and LRU reorder for one set row read from the line memory.
// ----------------------------------------------------------------------------
module slru_update #(
    parameter int MAX_WAYS = 8,
    parameter int WAY_W    = 3,
    parameter int CNT_W    = 4
) (
    input  wire logic [MAX_WAYS-1:0][slru_pkg::TAG_W-1:0] row_tags,
    input  wire logic [MAX_WAYS-1:0][WAY_W-1:0]           row_lru,
    input  wire logic [CNT_W-1:0]                         row_n,
    input  wire logic [CNT_W-1:0]                         ways,
    input  wire logic [slru_pkg::TAG_W-1:0]               tag,
    output slru_pkg::slru_status_t                        status,
    output logic [WAY_W-1:0]                              way,
    output logic [MAX_WAYS-1:0][WAY_W-1:0]                new_lru,
    output logic [CNT_W-1:0]                              new_n
);
    import slru_pkg::*;

    logic [MAX_WAYS-1:0] match;
    logic                hit;
    logic [WAY_W-1:0]    hit_way;
    logic [CNT_W-1:0]    pos;
    logic                pos_found;
    logic                fill;

    // per-way tag compare; ways below the fill count are the valid ones
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            match[i] = (CNT_W'(i) < row_n) && (row_tags[i] == tag);
        end
    end

    // first matching way, then its place in the recency order
    always_comb
    begin
        hit       = 1'b0;
        hit_way   = '0;
        pos       = '0;
        pos_found = 1'b0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (match[i] && !hit)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
        end
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (!pos_found && (CNT_W'(i) < row_n) && (row_lru[i] == hit_way))
            begin
                pos_found = 1'b1;
                pos       = CNT_W'(i);
            end
        end
    end

    assign fill = !hit && (row_n < ways);

    always_comb
    begin
        status.hit   = hit;
        status.evict = !hit && !fill;
        new_n        = fill ? row_n + CNT_W'(1) : row_n;
        if (hit)
            way = hit_way;
        else if (fill)
            way = row_n[WAY_W-1:0];
        else
            way = row_lru[0];

        for (int i = 0; i < MAX_WAYS; i++)
        begin
            new_lru[i] = row_lru[i];
            if (fill)
            begin
                if (CNT_W'(i) == row_n)
                    new_lru[i] = WAY_W'(i);
            end
            else
            begin
                // hit: shift from pos, eviction: shift from the front
                if ((hit ? (CNT_W'(i) >= pos) : 1'b1) && (CNT_W'(i + 1) < row_n)
                    && (i + 1 < MAX_WAYS))
                    new_lru[i] = row_lru[(i + 1) % MAX_WAYS];
                if (CNT_W'(i + 1) == row_n)
                    new_lru[i] = way;
            end
        end
    end

endmodule : slru_update
`default_nettype wire

/* rtl/set_associative_lru_cache_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_associative_lru_cache_top
// Tag-only set-associative cache with true LRU replacement and hit, miss and
// eviction totals.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Fields                                       Notes
// req      in   action[1:0], access_address[63:0]            valid/ready
// rsp      out  hit, evicted, last, hit_count[31:0],         valid/ready,
//               miss_count[31:0], eviction_count[31:0]       registered
// cfg      in   cfg_we, cfg_index[1:0], cfg_data[5:0]        write only
//
// Load/store: a memory read, then lookup and write back. Modify: two
// read-modify-write passes over the same set. Instruction fetch: taken
// with no result. The rate is set by the single-port set memory and its
// registered read.
// Reset and a write to a defined configuration register clear the per-set
// valid flops at once; no clearing pass. Totals survive configuration writes.
// A stalled result holds the lookup in place; the result register lets
// the next request be taken while a result waits.
// ----------------------------------------------------------------------------
module set_associative_lru_cache_top #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [slru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [slru_pkg::CFG_DATA_W-1:0] cfg_data,
    slru_req_if.sink                            req,
    slru_rsp_if.source                          rsp
);
    import slru_pkg::*;

    // largest set_bits with 2^k <= MAX_SETS
    localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W  = $clog2(MAX_WAYS + 1);

    typedef struct packed {
        logic [MAX_WAYS-1:0][TAG_W-1:0] tags;
        logic [MAX_WAYS-1:0][WAY_W-1:0] lru;
        logic [CNT_W-1:0]               n;
    } row_t;

    typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_REREAD} state_t;

    // ---------------- configuration ----------------
    logic [3:0] set_bits_reg;
    logic [5:0] block_bits_reg;
    logic [3:0] ways_used_reg;
    logic       cfg_flush;

    assign cfg_flush = cfg_we && ((cfg_index == CFG_SET_BITS) ||
                                  (cfg_index == CFG_BLOCK_BITS) ||
                                  (cfg_index == CFG_WAYS_USED));

    logic [3:0]       sb_eff;
    logic [6:0]       shift_amt;
    logic [4:0]       ways_ext;
    logic [CNT_W-1:0] ways_eff;

    assign sb_eff    = (set_bits_reg < 4'(SB_MAX)) ? set_bits_reg : 4'(SB_MAX);
    assign shift_amt = {3'b000, sb_eff} + {1'b0, block_bits_reg};
    assign ways_ext  = {1'b0, ways_used_reg};

    always_comb
    begin
        if (ways_ext == 5'd0)
            ways_eff = CNT_W'(1);
        else if (ways_ext > 5'(MAX_WAYS))
            ways_eff = CNT_W'(MAX_WAYS);
        else
            ways_eff = CNT_W'(ways_ext);
    end

    // ---------------- address split on the request ----------------
    logic [ADDR_W-1:0] addr_shifted;
    logic [SET_W:0]    set_mask;
    logic [SET_W-1:0]  in_set;
    logic [TAG_W-1:0]  in_tag;

    assign addr_shifted = req.access_address >> block_bits_reg;
    assign set_mask     = ((SET_W + 1)'(1) << sb_eff) - (SET_W + 1)'(1);
    assign in_set       = addr_shifted[SET_W-1:0] & set_mask[SET_W-1:0];
    assign in_tag       = shift_amt[6] ? '0 : (req.access_address >> shift_amt[5:0]);

    // ---------------- control ----------------
    state_t           state_reg;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             modify_reg;

    logic               rsp_valid_reg;
    logic               rsp_hit_reg;
    logic               rsp_evicted_reg;
    logic               rsp_last_reg;
    logic [CNT32_W-1:0] hits_total_reg;
    logic [CNT32_W-1:0] misses_total_reg;
    logic [CNT32_W-1:0] evictions_total_reg;

    logic req_fire;
    logic req_take;
    logic out_free;
    logic do_update;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign req_take  = req_fire && (req.action != ACT_IFETCH);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign do_update = (state_reg == ST_LOOKUP) && out_free;

    // ---------------- set memory ----------------
    row_t             row_mem [MAX_SETS];
    logic [MAX_SETS-1:0] row_valid_reg;
    row_t             rd_row_reg;
    logic             rd_row_valid_reg;
    logic             mem_re;
    logic [SET_W-1:0] rd_addr;
    row_t             wr_row;

    assign mem_re  = req_take || (state_reg == ST_REREAD);
    assign rd_addr = (state_reg == ST_REREAD) ? set_reg : in_set;

    always_ff @(posedge clk)
    begin
        if (do_update)
            row_mem[set_reg] <= wr_row;
        if (mem_re)
        begin
            rd_row_reg       <= row_mem[rd_addr];
            rd_row_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    // a set not yet written since reset or flush has no lines in use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_valid_reg <= '0;
        else if (cfg_flush)
            row_valid_reg <= '0;
        else if (do_update)
            row_valid_reg[set_reg] <= 1'b1;
    end

    // ---------------- lookup and LRU update ----------------
    logic [CNT_W-1:0]               rd_n;
    slru_status_t                   upd_status;
    logic [WAY_W-1:0]               upd_way;
    logic [MAX_WAYS-1:0][WAY_W-1:0] upd_lru;
    logic [CNT_W-1:0]               upd_n;

    assign rd_n = rd_row_valid_reg ? rd_row_reg.n : '0;

    slru_update #(
        .MAX_WAYS (MAX_WAYS),
        .WAY_W    (WAY_W),
        .CNT_W    (CNT_W)
    ) u_update (
        .row_tags (rd_row_reg.tags),
        .row_lru  (rd_row_reg.lru),
        .row_n    (rd_n),
        .ways     (ways_eff),
        .tag      (tag_reg),
        .status   (upd_status),
        .way      (upd_way),
        .new_lru  (upd_lru),
        .new_n    (upd_n)
    );

    always_comb
    begin
        wr_row      = rd_row_reg;
        wr_row.lru  = upd_lru;
        wr_row.n    = upd_n;
        if (!upd_status.hit)
            wr_row.tags[upd_way] = tag_reg;
    end

    // saturating totals after this access
    logic [CNT32_W-1:0] hits_next;
    logic [CNT32_W-1:0] misses_next;
    logic [CNT32_W-1:0] evictions_next;

    always_comb
    begin
        hits_next      = hits_total_reg;
        misses_next    = misses_total_reg;
        evictions_next = evictions_total_reg;
        if (upd_status.hit && (hits_total_reg != '1))
            hits_next = hits_total_reg + CNT32_W'(1);
        if (!upd_status.hit && (misses_total_reg != '1))
            misses_next = misses_total_reg + CNT32_W'(1);
        if (upd_status.evict && (evictions_total_reg != '1))
            evictions_next = evictions_total_reg + CNT32_W'(1);
    end

    // ---------------- state machine, config and result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            set_bits_reg        <= 4'd0;
            block_bits_reg      <= 6'd0;
            ways_used_reg       <= 4'd1;
            modify_reg          <= 1'b0;
            rsp_valid_reg       <= 1'b0;
            rsp_hit_reg         <= 1'b0;
            rsp_evicted_reg     <= 1'b0;
            rsp_last_reg        <= 1'b0;
            hits_total_reg      <= '0;
            misses_total_reg    <= '0;
            evictions_total_reg <= '0;
            set_reg             <= '0;
            tag_reg             <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SET_BITS:   set_bits_reg   <= cfg_data[3:0];
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                    CFG_WAYS_USED:  ways_used_reg  <= cfg_data[3:0];
                    default: ;
                endcase
            end

            // a result loaded by the lookup below replaces the one leaving
            if (rsp_valid_reg && rsp.ready && !do_update)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_take)
                    begin
                        set_reg    <= in_set;
                        tag_reg    <= in_tag;
                        modify_reg <= (req.action == ACT_MODIFY);
                        state_reg  <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg       <= 1'b1;
                        rsp_hit_reg         <= upd_status.hit;
                        rsp_evicted_reg     <= upd_status.evict;
                        rsp_last_reg        <= !modify_reg;
                        hits_total_reg      <= hits_next;
                        misses_total_reg    <= misses_next;
                        evictions_total_reg <= evictions_next;
                        if (modify_reg)
                        begin
                            // store half of a modify: read the set again
                            modify_reg <= 1'b0;
                            state_reg  <= ST_REREAD;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_REREAD:
                begin
                    state_reg <= ST_LOOKUP;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.hit            = rsp_hit_reg;
    assign rsp.evicted        = rsp_evicted_reg;
    assign rsp.last           = rsp_last_reg;
    assign rsp.hit_count      = hits_total_reg;
    assign rsp.miss_count     = misses_total_reg;
    assign rsp.eviction_count = evictions_total_reg;

`ifndef SYNTHESIS
    // fill count of a live set never exceeds the configured associativity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> (rd_n <= ways_eff))
        else $error("set fill count exceeds associativity");

    // an eviction only happens on a full set
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (do_update && upd_status.evict) |-> (rd_n == ways_eff))
        else $error("eviction from a set that is not full");

    // a result is never both a hit and an eviction
    a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_hit_reg && rsp_evicted_reg))
        else $error("result flags both hit and eviction");

    // hit and miss totals never go backwards
    a_totals_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (hits_total_reg >= $past(hits_total_reg)) &&
        (misses_total_reg >= $past(misses_total_reg)))
        else $error("running total decreased");
`endif

endmodule : set_associative_lru_cache_top
`default_nettype wire

/* tb/slru_cache_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slru_cache_checker
// Watches the access and result channels and the register port, keeps a
// shadow of tags, recency order and totals, and compares every result.
// ----------------------------------------------------------------------------
module slru_cache_checker
    import slru_pkg::*;
#(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    slru_req_if                   req,
    slru_rsp_if                   rsp,
    output int unsigned           failures,
    output int unsigned           outstanding
);

    localparam int SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic               hit;
        logic               evicted;
        logic               last;
        logic [CNT32_W-1:0] hit_count;
        logic [CNT32_W-1:0] miss_count;
        logic [CNT32_W-1:0] eviction_count;
    } access_outcome_t;

    logic               line_valid [MAX_SETS][MAX_WAYS];
    logic [TAG_W-1:0]   line_tag   [MAX_SETS][MAX_WAYS];
    logic [WAY_W-1:0]   recency    [MAX_SETS][MAX_WAYS];   // least recent first
    int unsigned        fill_count [MAX_SETS];
    logic [CNT32_W-1:0] hits_seen;
    logic [CNT32_W-1:0] misses_seen;
    logic [CNT32_W-1:0] evictions_seen;
    logic [3:0]         set_bits_reg;
    logic [5:0]         block_bits_reg;
    logic [3:0]         ways_reg;

    access_outcome_t    pending_outcomes [$];
    access_outcome_t    want;
    access_outcome_t    got;
    int unsigned        mismatch_total = 0;

    assign failures = mismatch_total;

    function automatic logic [CNT32_W-1:0] bump(input logic [CNT32_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void flush_lines();
        for (int s = 0; s < MAX_SETS; s++)
        begin
            fill_count[s] = 0;
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                line_valid[s][w] = 1'b0;
                recency[s][w]    = '0;
            end
        end
    endfunction

    // one lookup plus update of the set; returns flags and totals after it
    function automatic access_outcome_t cache_access(input logic [ADDR_W-1:0] addr,
                                                     input logic              is_last);
        int unsigned      sb;
        int unsigned      shift;
        int unsigned      ways;
        int unsigned      n;
        int unsigned      set;
        int unsigned      way;
        int unsigned      pos;
        logic [TAG_W-1:0] tag;
        logic             hit;
        logic             evict;
        access_outcome_t  res;

        sb    = (set_bits_reg > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_reg;
        shift = sb + block_bits_reg;
        tag   = (shift >= TAG_W) ? '0 : addr >> shift;
        set   = int'((addr >> block_bits_reg) & ((64'd1 << sb) - 64'd1));
        ways  = (ways_reg == 0) ? 1 : ((ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg);
        n     = (fill_count[set] > ways) ? ways : fill_count[set];
        hit   = 1'b0;
        evict = 1'b0;
        way   = 0;

        for (int i = 0; i < n; i++)
        begin
            if (line_valid[set][i] && line_tag[set][i] == tag)
            begin
                hit = 1'b1;
                way = i;
                break;
            end
        end

        if (hit)
        begin
            hits_seen = bump(hits_seen);
            pos = n - 1;
            for (int i = 0; i < n; i++)
            begin
                if (recency[set][i] == way)
                begin
                    pos = i;
                    break;
                end
            end
            for (int i = pos; i + 1 < n; i++)
                recency[set][i] = recency[set][i + 1];
            recency[set][n - 1] = WAY_W'(way);
        end
        else
        begin
            misses_seen = bump(misses_seen);
            if (n < ways)
            begin
                way = n;
                recency[set][n] = WAY_W'(n);
                n++;
            end
            else
            begin
                evict          = 1'b1;
                evictions_seen = bump(evictions_seen);
                way            = recency[set][0] % MAX_WAYS;
                for (int i = 0; i + 1 < n; i++)
                    recency[set][i] = recency[set][i + 1];
                recency[set][n - 1] = WAY_W'(way);
            end
            line_valid[set][way] = 1'b1;
            line_tag[set][way]   = tag;
            fill_count[set]      = n;
        end

        res.hit            = hit;
        res.evicted        = evict;
        res.last           = is_last;
        res.hit_count      = hits_seen;
        res.miss_count     = misses_seen;
        res.eviction_count = evictions_seen;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_lines();
            hits_seen      = '0;
            misses_seen    = '0;
            evictions_seen = '0;
            set_bits_reg   = '0;
            block_bits_reg = '0;
            ways_reg       = 4'd1;
            pending_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            // results first: a result never belongs to a request taken at the same edge
            if (rsp.valid && rsp.ready)
            begin
                got.hit            = rsp.hit;
                got.evicted        = rsp.evicted;
                got.last           = rsp.last;
                got.hit_count      = rsp.hit_count;
                got.miss_count     = rsp.miss_count;
                got.eviction_count = rsp.eviction_count;
                if (pending_outcomes.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_MAX)
                        $display("[%0t] result transaction with nothing expected", $time);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (got !== want)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_MAX)
                            $display({"[%0t] result mismatch (exp/got): hit %0b/%0b ",
                                      "evicted %0b/%0b last %0b/%0b hits %0d/%0d ",
                                      "misses %0d/%0d evictions %0d/%0d"},
                                     $time, want.hit, got.hit, want.evicted, got.evicted,
                                     want.last, got.last, want.hit_count, got.hit_count,
                                     want.miss_count, got.miss_count,
                                     want.eviction_count, got.eviction_count);
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                if (req.action == ACT_MODIFY)
                begin
                    pending_outcomes.push_back(cache_access(req.access_address, 1'b0));
                    pending_outcomes.push_back(cache_access(req.access_address, 1'b1));
                end
                else if (req.action != ACT_IFETCH)
                    pending_outcomes.push_back(cache_access(req.access_address, 1'b1));
            end

            // known registers flush the lines; totals survive
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SET_BITS:
                    begin
                        set_bits_reg = cfg_data[3:0];
                        flush_lines();
                    end
                    CFG_BLOCK_BITS:
                    begin
                        block_bits_reg = cfg_data[5:0];
                        flush_lines();
                    end
                    CFG_WAYS_USED:
                    begin
                        ways_reg = cfg_data[3:0];
                        flush_lines();
                    end
                    default: ;
                endcase
            end

            outstanding <= pending_outcomes.size();
        end
    end

endmodule : slru_cache_checker

/* tb/tb_set_associative_lru_cache_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_associative_lru_cache_top
// Drives accesses and register writes into the LRU cache over several
// geometries and handshake pressures; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_set_associative_lru_cache_top;
    import slru_pkg::*;

    localparam int MAX_SETS      = 256;
    localparam int MAX_WAYS      = 8;
    // Slowest run is roughly 650 accesses with sender gaps, modify passes and
    // two results per modify under 59% stall, plus drains.
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 8;     // covers an ifetch or modify still in flight
    localparam int PHASE_ITEMS   = 90;    // counted transactions per random phase
    localparam int POOL_MAX      = 2 * MAX_WAYS + 4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;   // no register there

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned           failures;
    int unsigned           outstanding;
    int unsigned           cycle_count = 0;

    // handshake pressure, percent of cycles
    int unsigned           idle_pct;
    int unsigned           stall_pct;

    // effective geometry, used only to shape addresses
    int unsigned           cur_set_bits;
    int unsigned           cur_block_bits;
    int unsigned           cur_ways;

    // block addresses reused within a phase so that hits and evictions occur
    logic [ADDR_W-1:0]     block_pool [POOL_MAX];
    int unsigned           pool_size;

    slru_req_if req_bus ();
    slru_rsp_if rsp_bus ();

    set_associative_lru_cache_top #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    slru_cache_checker #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req_bus),
        .rsp         (rsp_bus),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("set_associative_lru_cache_top regression: fail");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
        rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Present one access transaction; optional idle cycles come first. Valid is
    // left high on return so back-to-back transactions need no extra step.
    task automatic send_access(input logic [ACT_W-1:0]  act,
                               input logic [ADDR_W-1:0] addr);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.action         <= act;
        req_bus.access_address <= addr;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
    endtask

    // Stop sending, wait for every expected result, then let the block go idle.
    task automatic settle();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Caller keeps cfg_we high across back-to-back writes and lowers it after.
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] sb,
                             input logic [CFG_DATA_W-1:0] bb,
                             input logic [CFG_DATA_W-1:0] ways);
        settle();
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_BLOCK_BITS, bb);
        write_reg(CFG_WAYS_USED, ways);
        cfg_we <= 1'b0;
        // register keeps 4 bits of set_bits and ways; set count saturates
        cur_set_bits   = (sb[3:0] > 8) ? 8 : sb[3:0];
        cur_block_bits = bb;
        cur_ways       = (ways[3:0] == 0) ? 1 : ((ways[3:0] > MAX_WAYS) ? MAX_WAYS
                                                                        : ways[3:0]);
    endtask

    // One random phase: new geometry, new pressure, then PHASE_ITEMS counted
    // transactions. Most addresses come from a pool of blocks crowded into two
    // sets so that the set overflows its ways; the rest are fully random.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] sb,
                             input logic [CFG_DATA_W-1:0] bb,
                             input logic [CFG_DATA_W-1:0] ways,
                             input int unsigned           sender_idle,
                             input int unsigned           receiver_stall,
                             input bit                    poke_unused);
        logic [ADDR_W-1:0] set_field;
        logic [ADDR_W-1:0] offset_mask;
        logic [ADDR_W-1:0] addr;
        logic [ACT_W-1:0]  act;
        int unsigned       counted;

        configure(sb, bb, ways);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;

        set_field   = ((64'd1 << cur_set_bits) - 64'd1) << cur_block_bits;
        offset_mask = (64'd1 << cur_block_bits) - 64'd1;
        pool_size   = 2 * cur_ways + 3;
        for (int i = 0; i < pool_size; i++)
            block_pool[i] = (rand64() & ~set_field)
                          | ((64'($urandom_range(1)) << cur_block_bits) & set_field);

        counted = 0;
        while (counted < PHASE_ITEMS)
        begin
            act = ($urandom_range(99) < 15) ? ACT_IFETCH : ACT_W'($urandom_range(2));
            if ($urandom_range(99) < 85)
                addr = (block_pool[$urandom_range(pool_size - 1)] & ~offset_mask)
                     | (rand64() & offset_mask);
            else
                addr = rand64();
            send_access(act, addr);
            if (act != ACT_IFETCH)
                counted++;

            // now and then hold off until the result side has drained
            if ($urandom_range(49) == 0)
                settle();

            // a write to the spare index must leave the cached lines alone
            if (poke_unused && act != ACT_IFETCH && counted == PHASE_ITEMS / 2)
            begin
                settle();
                write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
                cfg_we <= 1'b0;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_SET_BITS;
        cfg_data               <= '0;
        req_bus.valid          <= 1'b0;
        req_bus.action         <= ACT_LOAD;
        req_bus.access_address <= '0;
        idle_pct       = 0;
        stall_pct      = 0;
        cur_set_bits   = 0;
        cur_block_bits = 0;
        cur_ways       = 1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: one set, one way, tag is the whole address, so each
        // new block evicts the resident one.
        send_access(ACT_LOAD, 64'h0);                      // cold miss
        send_access(ACT_STORE, 64'h0);                     // hit
        send_access(ACT_MODIFY, 64'h0);                    // two hits
        send_access(ACT_IFETCH, '1);                       // ignored
        send_access(ACT_LOAD, '1);                         // miss, evicts 0
        send_access(ACT_STORE, 64'h0);                     // miss, evicts all-ones
        send_access(ACT_MODIFY, 64'h8000_0000_0000_0001);  // miss+evict, then hit
        send_access(ACT_LOAD, 64'h8000_0000_0000_0001);    // hit
        send_access(ACT_IFETCH, 64'h0);                    // ignored
        send_access(ACT_STORE, '1);
        send_access(ACT_MODIFY, '1);
        send_access(ACT_LOAD, 64'h5555_5555_5555_5555);
        send_access(ACT_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_access(ACT_STORE, 64'hAAAA_AAAA_AAAA_AAAA);

        // Two sets of two ways, set index is address bit 0: LRU choice and
        // promotion on a hit.
        configure(6'd1, 6'd0, 6'd2);
        send_access(ACT_LOAD, 64'h0);
        send_access(ACT_LOAD, 64'h2);
        send_access(ACT_LOAD, 64'h4);                      // evicts 0x0
        send_access(ACT_LOAD, 64'h2);                      // hit, now most recent
        send_access(ACT_LOAD, 64'h0);                      // evicts 0x4
        send_access(ACT_STORE, 64'h2);                     // still resident
        send_access(ACT_MODIFY, 64'h3);                    // set 1: miss then hit
        send_access(ACT_LOAD, 64'h4);                      // evicts 0x0

        // Random phases. Set-bit values above the limit saturate, ways of zero
        // act as one, ways past the limit clamp, and set+block bits of 64 or
        // more leave a zero tag. Upper data bits of 4-bit registers drop out.
        run_phase(6'd2,  6'd4,  6'd2,  0,  0,  1'b0);
        run_phase(6'h3F, 6'd6,  6'h3F, 59, 0,  1'b0);
        run_phase(6'd8,  6'd63, 6'd8,  0,  59, 1'b0);
        run_phase(6'd0,  6'd32, 6'd0,  9,  9,  1'b1);
        run_phase(6'h31, 6'd62, 6'd4,  0,  0,  1'b0);
        run_phase(6'd3,  6'd61, 6'd5,  0,  59, 1'b0);

        idle_pct = 0;
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("set_associative_lru_cache_top regression: pass");
        else
            $display("set_associative_lru_cache_top regression: fail");
        $finish;
    end

endmodule : tb_set_associative_lru_cache_top
